// File: sv/hsv_to_argb_pixel_macros.svh
// Assertion helpers for the HSV to ARGB converter
`ifndef HSV_TO_ARGB_PIXEL_MACROS_SVH
`define HSV_TO_ARGB_PIXEL_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HSV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("hsv_to_argb_pixel: assertion failed");

// next-cycle implication, disabled while in reset
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hsv_to_argb_pixel: assertion failed");

`endif

// File: sv/hsv2argb_pkg.sv
package hsv2argb_pkg;

	// 65535 * 65536, the full-scale product term
	localparam logic [31:0] FULL_FRAC = 32'hFFFF_0000;

	localparam logic [2:0] SEC_R_TO_Y = 3'd0;
	localparam logic [2:0] SEC_Y_TO_G = 3'd1;
	localparam logic [2:0] SEC_G_TO_C = 3'd2;
	localparam logic [2:0] SEC_C_TO_B = 3'd3;
	localparam logic [2:0] SEC_B_TO_M = 3'd4;
	localparam logic [2:0] SEC_M_TO_R = 3'd5;

	// floor(n / 65535) for n <= 65535*65535: n = q0*65535 + (q0 + lo)
	function automatic logic [15:0] div65535(input logic [31:0] n);
		logic [16:0] r;
		logic [16:0] q;
		r = {1'b0, n[15:0]} + {1'b0, n[31:16]};
		q = {1'b0, n[31:16]};
		if (r >= 17'd131070) begin
			q = q + 17'd2;
		end else if (r >= 17'd65535) begin
			q = q + 17'd1;
		end
		return q[15:0];
	endfunction

	// floor(x / 257): x >> 8 overshoots by at most one
	function automatic logic [7:0] div257(input logic [15:0] x);
		logic [7:0]  q;
		logic [16:0] m;
		q = x[15:8];
		m = {1'b0, q, 8'b0} + {9'b0, q};
		if (m > {1'b0, x}) begin
			q = q - 8'd1;
		end
		return q;
	endfunction

endpackage

// File: sv/hsv_to_argb_pixel.sv
// channel  | dir | signals                                  | transfer
// ---------+-----+------------------------------------------+---------------------------
// pixel in | in  | start, busy, hue, saturation, brightness,| start & !busy at clk edge
//          |     | alpha                                    |
// pixel out| out | done, argb                               | done high for one cycle
//
// Five-stage pipeline: one pixel per clock, result on done once it has passed stages s1 to s5.
// The stages are split around the two rows of multipliers (s2, s3) and the two
// constant-divide corrections (s4, s5).
// arst_n clears the valid bits only; busy is never raised since the output side
// cannot stall and the pipeline holds no state between pixels.
`include "hsv_to_argb_pixel_macros.svh"

module hsv_to_argb_pixel
	import hsv2argb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] hue,
	input  logic [15:0] saturation,
	input  logic [15:0] brightness,
	input  logic [15:0] alpha,
	output logic        done,
	output logic [31:0] argb
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// stage 1
	logic [2:0]  sector_s1;
	logic [15:0] frac_s1, sat_s1, val_s1, alpha_s1;
	logic        grey_s1;
	// stage 2
	logic [2:0]  sector_s2;
	logic        grey_s2;
	logic [15:0] val_s2;
	logic [31:0] sf_s2, sg_s2, n1_s2;
	logic [7:0]  vch_s2, ach_s2;
	// stage 3
	logic [2:0]  sector_s3;
	logic        grey_s3;
	logic [31:0] n1_s3, n2_s3, n3_s3;
	logic [7:0]  vch_s3, ach_s3;
	// stage 4
	logic [2:0]  sector_s4;
	logic        grey_s4;
	logic [15:0] q1_s4, q2_s4, q3_s4;
	logic [7:0]  vch_s4, ach_s4;
	// stage 5
	logic [31:0] argb_s5;

	logic [18:0] hue6;
	logic [16:0] frac_c;
	logic [32:0] sg_full;
	logic [47:0] n2_full, n3_full;
	logic [7:0]  p1, p2, p3, red, green, blue;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign hue6 = ({3'b0, hue} << 2) + ({3'b0, hue} << 1);

	always_ff @(posedge clk) begin
		sector_s1 <= hue6[18:16];
		frac_s1   <= hue6[15:0];
		sat_s1    <= saturation;
		val_s1    <= brightness;
		alpha_s1  <= alpha;
		grey_s1   <= (saturation == 16'd0);
	end

	assign frac_c  = 17'h10000 - {1'b0, frac_s1};
	assign sg_full = {17'b0, sat_s1} * {16'b0, frac_c};

	always_ff @(posedge clk) begin
		sector_s2 <= sector_s1;
		grey_s2   <= grey_s1;
		val_s2    <= val_s1;
		sf_s2     <= {16'b0, sat_s1} * {16'b0, frac_s1};
		sg_s2     <= sg_full[31:0];
		n1_s2     <= {16'b0, val_s1} * {16'b0, 16'hFFFF - sat_s1};
		vch_s2    <= div257(val_s1);
		ach_s2    <= div257(alpha_s1);
	end

	// only the top 32 bits survive the divide by 65536
	assign n2_full = {32'b0, val_s2} * {16'b0, FULL_FRAC - sf_s2};
	assign n3_full = {32'b0, val_s2} * {16'b0, FULL_FRAC - sg_s2};

	always_ff @(posedge clk) begin
		sector_s3 <= sector_s2;
		grey_s3   <= grey_s2;
		n1_s3     <= n1_s2;
		n2_s3     <= n2_full[47:16];
		n3_s3     <= n3_full[47:16];
		vch_s3    <= vch_s2;
		ach_s3    <= ach_s2;
	end

	always_ff @(posedge clk) begin
		sector_s4 <= sector_s3;
		grey_s4   <= grey_s3;
		q1_s4     <= div65535(n1_s3);
		q2_s4     <= div65535(n2_s3);
		q3_s4     <= div65535(n3_s3);
		vch_s4    <= vch_s3;
		ach_s4    <= ach_s3;
	end

	assign p1 = div257(q1_s4);
	assign p2 = div257(q2_s4);
	assign p3 = div257(q3_s4);

	always_comb begin
		if (grey_s4) begin
			red   = vch_s4;
			green = vch_s4;
			blue  = vch_s4;
		end else begin
			case (sector_s4)
				SEC_R_TO_Y: begin red = vch_s4; green = p3;     blue = p1;     end
				SEC_Y_TO_G: begin red = p2;     green = vch_s4; blue = p1;     end
				SEC_G_TO_C: begin red = p1;     green = vch_s4; blue = p3;     end
				SEC_C_TO_B: begin red = p1;     green = p2;     blue = vch_s4; end
				SEC_B_TO_M: begin red = p3;     green = p1;     blue = vch_s4; end
				// magenta to red; sector codes above it never occur
				default: begin red = vch_s4; green = p1; blue = p2; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		argb_s5 <= {ach_s4, red, green, blue};
	end

	assign done = valid_s5;
	assign argb = argb_s5;

	`HSV_ASSERT_IMPL(a_latency, clk, arst_n, start && !busy, ##5 done)
	`HSV_ASSERT_NEXT(a_no_spurious, clk, arst_n, !valid_s4, !done)
	`HSV_ASSERT_NEXT(a_grey_equal, clk, arst_n, valid_s4 && grey_s4,
		argb[23:16] == argb[15:8] && argb[15:8] == argb[7:0])

endmodule
